@@ rtl/core/litpi_pkg.sv @@
// Shared types, codes and the quotient saturation helper for the line unit.
// No dependencies; used by every module in rtl/core except litpi_div.
package litpi_pkg;

	localparam logic OP_MAKE  = 1'b0;
	localparam logic OP_CROSS = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_PARALLEL = 2'd1,
		ST_SAT      = 2'd2
	} status_t;

	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	// carried alongside the first divider
	typedef struct packed {
		logic               op;
		logic               vert;
		logic               par;
		logic signed [31:0] mop;    // multiplied by the first quotient
		logic signed [31:0] cterm;  // constant term, scaled by one for intersect
		logic signed [31:0] dvs;    // second divisor
	} side1_t;

	// carried alongside the second divider
	typedef struct packed {
		logic               op;
		logic               vert;
		logic               par;
		logic               ovf;
		logic signed [31:0] x;
	} side2_t;

	typedef struct packed {
		logic               ovf;
		logic signed [31:0] val;
	} sat_t;

	// magnitude quotient (big = at least 2^32) plus sign -> saturated signed value
	function automatic sat_t sat_quo(input logic [31:0] q, input logic big, input logic neg);
		sat_t r;
		r.ovf = 1'b0;
		r.val = $signed(q);
		if (big) begin
			r.ovf = 1'b1;
			r.val = neg ? Q_MIN : Q_MAX;
		end else if (neg) begin
			if (q > 32'h8000_0000) begin
				r.ovf = 1'b1;
				r.val = Q_MIN;
			end else begin
				r.val = $signed(~q + 32'd1);
			end
		end else if (q[31]) begin
			r.ovf = 1'b1;
			r.val = Q_MAX;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/litpi_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on nothing; instantiated twice by the top level.
module litpi_div #(
	parameter int NW = 64,
	parameter int DW = 64,
	parameter int QW = 32,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic          in_neg,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [QW-1:0] out_quo,
	output logic          out_big,
	output logic          out_neg,
	output logic [SW-1:0] out_side
);

	localparam int W = ((NW > DW + QW) ? NW : DW + QW) + 1;

	logic [W-1:0]  rem_s  [0:QW];
	logic [DW-1:0] den_s  [0:QW];
	logic [QW-1:0] quo_s  [0:QW];
	logic [SW-1:0] side_s [0:QW];
	logic          vld_s  [0:QW];
	logic          neg_s  [0:QW];
	logic          big_s  [0:QW];
	logic          big_in;

	// quotient would need more than QW bits
	assign big_in = W'(in_num) >= (W'(in_den) << QW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= W'(in_num);
			den_s[0]  <= in_den;
			quo_s[0]  <= '0;
			side_s[0] <= in_side;
			neg_s[0]  <= in_neg;
			big_s[0]  <= big_in;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [W-1:0] part;
		logic         fit;

		assign part = W'(den_s[k-1]) << (QW - k);
		assign fit  = rem_s[k-1] >= part;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= fit ? rem_s[k-1] - part : rem_s[k-1];
				quo_s[k]  <= {quo_s[k-1][QW-2:0], fit};
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				big_s[k]  <= big_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign out_quo   = quo_s[QW];
	assign out_big   = big_s[QW];
	assign out_neg   = neg_s[QW];
	assign out_side  = side_s[QW];

endmodule

@@ rtl/core/litpi_front.sv @@
// Front stages: cross products, operand selection, magnitudes for the first divider.
// Depends on litpi_pkg.
module litpi_front #(
	parameter int FRAC_BITS    = 16,
	parameter int VERTICAL_EPS = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic                      operation,
	input  logic signed [31:0]        point_a_x,
	input  logic signed [31:0]        point_a_z,
	input  logic signed [31:0]        point_b_x,
	input  logic signed [31:0]        point_b_z,
	input  logic signed [31:0]        first_a,
	input  logic signed [31:0]        first_b,
	input  logic signed [31:0]        first_c,
	input  logic signed [31:0]        second_a,
	input  logic signed [31:0]        second_b,
	input  logic signed [31:0]        second_c,
	output logic                      out_valid,
	output logic [63+FRAC_BITS:0]     out_num,
	output logic [63:0]               out_den,
	output logic                      out_neg,
	output litpi_pkg::side1_t         out_side
);

	localparam logic signed [31:0] ONE   = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [32:0] EPS_P = 33'(VERTICAL_EPS);

	// stage 1: products
	logic signed [63:0] p_a1b2, p_a2b1, p_a1c2, p_a2c1;
	logic signed [32:0] dx_w, ndz_w;

	assign p_a1b2 = first_a * second_b;
	assign p_a2b1 = second_a * first_b;
	assign p_a1c2 = first_a * second_c;
	assign p_a2c1 = second_a * first_c;
	assign dx_w   = 33'(point_b_x) - 33'(point_a_x);
	assign ndz_w  = 33'(point_a_z) - 33'(point_b_z);

	logic               v_s1, op_s1, a1z_s1, a2z_s1;
	logic signed [63:0] a1b2_s1, a2b1_s1, a1c2_s1, a2c1_s1;
	logic signed [31:0] a1_s1, b1_s1, c1_s1, a2_s1, b2_s1, c2_s1, bx_s1, bz_s1;
	logic signed [32:0] dx_s1, ndz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= operation;
			a1z_s1  <= first_a == 32'sd0;
			a2z_s1  <= second_a == 32'sd0;
			a1b2_s1 <= p_a1b2;
			a2b1_s1 <= p_a2b1;
			a1c2_s1 <= p_a1c2;
			a2c1_s1 <= p_a2c1;
			a1_s1   <= first_a;
			b1_s1   <= first_b;
			c1_s1   <= first_c;
			a2_s1   <= second_a;
			b2_s1   <= second_b;
			c2_s1   <= second_c;
			bx_s1   <= point_b_x;
			bz_s1   <= point_b_z;
			dx_s1   <= dx_w;
			ndz_s1  <= ndz_w;
		end
	end

	// stage 2: branch select
	logic signed [64:0] num_w, den_w, n_w, d_w;
	logic               par_w, vert_w;
	litpi_pkg::side1_t  side_w;

	assign num_w  = 65'(a1c2_s1) - 65'(a2c1_s1);
	assign den_w  = 65'(a2b1_s1) - 65'(a1b2_s1);
	assign par_w  = a1b2_s1 == a2b1_s1;
	assign vert_w = (dx_s1 <= EPS_P) && (dx_s1 >= -EPS_P);

	always_comb begin
		n_w          = '0;
		d_w          = 65'sd1;
		side_w.op    = op_s1;
		side_w.vert  = (op_s1 == litpi_pkg::OP_MAKE) && vert_w;
		side_w.par   = (op_s1 == litpi_pkg::OP_CROSS) && par_w;
		side_w.mop   = '0;
		side_w.cterm = '0;
		side_w.dvs   = ONE;
		if (op_s1 == litpi_pkg::OP_MAKE) begin
			side_w.mop   = bx_s1;
			side_w.cterm = vert_w ? 32'sd0 : bz_s1;
			// c is already rescaled ahead of the second divider
			side_w.dvs   = 32'sd1;
			if (!vert_w) begin
				n_w = 65'(ndz_s1);
				d_w = 65'(dx_s1);
			end
		end else if (par_w) begin
			n_w = '0;
		end else if (a1z_s1) begin
			n_w          = -65'(c1_s1);
			d_w          = 65'(b1_s1);
			side_w.mop   = b2_s1;
			side_w.cterm = c2_s1;
			side_w.dvs   = a2_s1;
		end else if (a2z_s1) begin
			n_w          = -65'(c2_s1);
			d_w          = 65'(b2_s1);
			side_w.mop   = b1_s1;
			side_w.cterm = c1_s1;
			side_w.dvs   = a1_s1;
		end else begin
			n_w          = num_w;
			d_w          = den_w;
			side_w.mop   = b1_s1;
			side_w.cterm = c1_s1;
			side_w.dvs   = a1_s1;
		end
	end

	logic               v_s2;
	logic signed [64:0] n_s2, d_s2;
	litpi_pkg::side1_t  side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2    <= n_w;
			d_s2    <= d_w;
			side_s2 <= side_w;
		end
	end

	// stage 3: magnitudes, numerator prescaled by one
	logic [63:0] nmag_w, dmag_w;

	assign nmag_w = n_s2[64] ? 64'(-n_s2) : 64'(n_s2);
	assign dmag_w = d_s2[64] ? 64'(-d_s2) : 64'(d_s2);

	logic                  v_s3, neg_s3;
	logic [63+FRAC_BITS:0] num_s3;
	logic [63:0]           den_s3;
	litpi_pkg::side1_t     side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3  <= {nmag_w, {FRAC_BITS{1'b0}}};
			den_s3  <= dmag_w;
			neg_s3  <= n_s2[64] ^ d_s2[64];
			side_s3 <= side_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_num   = num_s3;
	assign out_den   = den_s3;
	assign out_neg   = neg_s3;
	assign out_side  = side_s3;

endmodule

@@ rtl/core/litpi_mid.sv @@
// Middle stages: saturate the first quotient, multiply, form the second dividend.
// Depends on litpi_pkg.
module litpi_mid #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [31:0]       in_quo,
	input  logic              in_big,
	input  logic              in_neg,
	input  litpi_pkg::side1_t in_side,
	output logic              out_valid,
	output logic [63:0]       out_num,
	output logic [31:0]       out_den,
	output logic              out_neg,
	output litpi_pkg::side2_t out_side
);

	localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
	localparam int                 SUMW = ((32 + FRAC_BITS > 64) ? 32 + FRAC_BITS : 64) + 1;

	// stage 4: saturate, apply vertical / parallel overrides
	litpi_pkg::sat_t    sat_w;
	logic signed [31:0] x_w;
	logic               ovf_w;

	assign sat_w = litpi_pkg::sat_quo(in_quo, in_big, in_neg);
	assign x_w   = in_side.par ? 32'sd0 : (in_side.vert ? ONE : sat_w.val);
	assign ovf_w = !in_side.par && !in_side.vert && sat_w.ovf;

	logic               v_s4, ovf_s4;
	logic signed [31:0] x_s4;
	litpi_pkg::side1_t  side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s4    <= x_w;
			ovf_s4  <= ovf_w;
			side_s4 <= in_side;
		end
	end

	// stage 5: product
	logic signed [63:0] prod_w;

	assign prod_w = x_s4 * side_s4.mop;

	logic               v_s5, ovf_s5;
	logic signed [31:0] x_s5;
	logic signed [63:0] prod_s5;
	litpi_pkg::side1_t  side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= prod_w;
			x_s5    <= x_s4;
			ovf_s5  <= ovf_s4;
			side_s5 <= side_s4;
		end
	end

	// stage 6: b*x + c*one; make-line uses bz + b*bx/one (bz is zero if vertical)
	// with only the product term truncated toward zero (divided by one here)
	logic signed [63:0]     pfl_w, ptr_w;
	logic                   rnd_w;
	logic signed [SUMW-1:0] sum_w;

	assign pfl_w = prod_s5 >>> FRAC_BITS;
	assign rnd_w = prod_s5[63] && (prod_s5[FRAC_BITS-1:0] != '0);
	assign ptr_w = pfl_w + $signed(64'(rnd_w));
	assign sum_w = (side_s5.op == litpi_pkg::OP_MAKE)
		? SUMW'(ptr_w) + SUMW'(side_s5.cterm)
		: SUMW'(prod_s5) + (SUMW'(side_s5.cterm) <<< FRAC_BITS);

	logic                   v_s6, ovf_s6;
	logic signed [31:0]     x_s6;
	logic signed [SUMW-1:0] sum_s6;
	litpi_pkg::side1_t      side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s6  <= sum_w;
			x_s6    <= x_s5;
			ovf_s6  <= ovf_s5;
			side_s6 <= side_s5;
		end
	end

	// stage 7: magnitudes; dividend is the negated sum
	logic [63:0]       nmag_w;
	logic [31:0]       dmag_w;
	logic              pos_w;
	litpi_pkg::side2_t side2_w;

	assign nmag_w = sum_s6[SUMW-1] ? 64'(-sum_s6) : 64'(sum_s6);
	assign dmag_w = side_s6.dvs[31] ? 32'(-side_s6.dvs) : 32'(side_s6.dvs);
	assign pos_w  = !sum_s6[SUMW-1] && (sum_s6 != '0);

	always_comb begin
		side2_w.op   = side_s6.op;
		side2_w.vert = side_s6.vert;
		side2_w.par  = side_s6.par;
		side2_w.ovf  = ovf_s6;
		side2_w.x    = x_s6;
	end

	logic              v_s7, neg_s7;
	logic [63:0]       num_s7;
	logic [31:0]       den_s7;
	litpi_pkg::side2_t side_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s7  <= nmag_w;
			den_s7  <= dmag_w;
			neg_s7  <= pos_w ^ side_s6.dvs[31];
			side_s7 <= side2_w;
		end
	end

	assign out_valid = v_s7;
	assign out_num   = num_s7;
	assign out_den   = den_s7;
	assign out_neg   = neg_s7;
	assign out_side  = side_s7;

endmodule

@@ rtl/core/line_through_points_and_intersect_unit.sv @@
// Top level of the 2D line unit: make-line and two-line intersect in Q16.16.
// Depends on litpi_pkg, litpi_front, litpi_div, litpi_mid.
//
// One request enters per clock and one result leaves per clock while res_stall
// does not hold the pipeline; the block is a single 74-stage pipeline (3 front
// stages, a 33-stage divider for the slope or intersection x, 4 stages to
// saturate, multiply and build the second dividend, a 33-stage divider for c or
// y, and the output register). Both dividers retire one quotient bit per stage.
// The whole pipeline advances together: a stalled result holds every stage and
// req_stall rises only while a result sits in the output register unaccepted.
// Make-line (operation 0) returns a*y + b*x + c = 0 with a = 1, b = -dz/dx, or
// a = 0, b = 1 when |dx| <= VERTICAL_EPS LSB. Intersect (operation 1) flags
// parallel or degenerate lines (a1*b2 == a2*b1, exact) with status 1 and zero
// outputs. Divisions truncate toward zero; any saturated output gives status 2.
module line_through_points_and_intersect_unit #(
	parameter int FRAC_BITS    = 16,
	parameter int VERTICAL_EPS = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               operation,
	input  logic signed [31:0] point_a_x,
	input  logic signed [31:0] point_a_z,
	input  logic signed [31:0] point_b_x,
	input  logic signed [31:0] point_b_z,
	input  logic signed [31:0] first_a,
	input  logic signed [31:0] first_b,
	input  logic signed [31:0] first_c,
	input  logic signed [31:0] second_a,
	input  logic signed [31:0] second_b,
	input  logic signed [31:0] second_c,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [31:0] coef_a,
	output logic signed [31:0] coef_b,
	output logic signed [31:0] coef_c,
	output logic signed [31:0] cross_x,
	output logic signed [31:0] cross_y,
	output logic [1:0]         status
);

	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
	localparam int S1W = $bits(litpi_pkg::side1_t);
	localparam int S2W = $bits(litpi_pkg::side2_t);

	// global advance: hold everything while the output register is blocked
	logic en;
	logic v_s8;

	assign en        = !v_s8 || !res_stall;
	assign req_stall = !en;

	// front: products and branch selection
	logic                  f_valid, f_neg;
	logic [63+FRAC_BITS:0] f_num;
	logic [63:0]           f_den;
	litpi_pkg::side1_t     f_side;

	litpi_front #(
		.FRAC_BITS    (FRAC_BITS),
		.VERTICAL_EPS (VERTICAL_EPS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req_valid),
		.operation (operation),
		.point_a_x (point_a_x),
		.point_a_z (point_a_z),
		.point_b_x (point_b_x),
		.point_b_z (point_b_z),
		.first_a   (first_a),
		.first_b   (first_b),
		.first_c   (first_c),
		.second_a  (second_a),
		.second_b  (second_b),
		.second_c  (second_c),
		.out_valid (f_valid),
		.out_num   (f_num),
		.out_den   (f_den),
		.out_neg   (f_neg),
		.out_side  (f_side)
	);

	// first divider: slope or intersection x
	logic              d1_valid, d1_big, d1_neg;
	logic [31:0]       d1_quo;
	logic [S1W-1:0]    d1_bits;
	litpi_pkg::side1_t d1_side;

	litpi_div #(
		.NW (64 + FRAC_BITS),
		.DW (64),
		.QW (32),
		.SW (S1W)
	) u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.in_num    (f_num),
		.in_den    (f_den),
		.in_neg    (f_neg),
		.in_side   (f_side),
		.out_valid (d1_valid),
		.out_quo   (d1_quo),
		.out_big   (d1_big),
		.out_neg   (d1_neg),
		.out_side  (d1_bits)
	);

	assign d1_side = litpi_pkg::side1_t'(d1_bits);

	// saturate, multiply, second dividend
	logic              m_valid, m_neg;
	logic [63:0]       m_num;
	logic [31:0]       m_den;
	litpi_pkg::side2_t m_side;

	litpi_mid #(
		.FRAC_BITS (FRAC_BITS)
	) u_mid (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d1_valid),
		.in_quo    (d1_quo),
		.in_big    (d1_big),
		.in_neg    (d1_neg),
		.in_side   (d1_side),
		.out_valid (m_valid),
		.out_num   (m_num),
		.out_den   (m_den),
		.out_neg   (m_neg),
		.out_side  (m_side)
	);

	// second divider: c term or intersection y
	logic              d2_valid, d2_big, d2_neg;
	logic [31:0]       d2_quo;
	logic [S2W-1:0]    d2_bits;
	litpi_pkg::side2_t d2_side;

	litpi_div #(
		.NW (64),
		.DW (32),
		.QW (32),
		.SW (S2W)
	) u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (m_valid),
		.in_num    (m_num),
		.in_den    (m_den),
		.in_neg    (m_neg),
		.in_side   (m_side),
		.out_valid (d2_valid),
		.out_quo   (d2_quo),
		.out_big   (d2_big),
		.out_neg   (d2_neg),
		.out_side  (d2_bits)
	);

	assign d2_side = litpi_pkg::side2_t'(d2_bits);

	// output stage: final saturation and result assembly
	litpi_pkg::sat_t    sat2_w;
	logic signed [31:0] ca_w, cb_w, cc_w, cx_w, cy_w;
	litpi_pkg::status_t st_w;

	assign sat2_w = litpi_pkg::sat_quo(d2_quo, d2_big, d2_neg);

	always_comb begin
		ca_w = '0;
		cb_w = '0;
		cc_w = '0;
		cx_w = '0;
		cy_w = '0;
		st_w = litpi_pkg::ST_OK;
		if (d2_side.op == litpi_pkg::OP_MAKE) begin
			ca_w = d2_side.vert ? 32'sd0 : ONE;
			cb_w = d2_side.x;
			cc_w = sat2_w.val;
			if (d2_side.ovf || sat2_w.ovf) begin
				st_w = litpi_pkg::ST_SAT;
			end
		end else if (d2_side.par) begin
			st_w = litpi_pkg::ST_PARALLEL;
		end else begin
			cx_w = d2_side.x;
			cy_w = sat2_w.val;
			if (d2_side.ovf || sat2_w.ovf) begin
				st_w = litpi_pkg::ST_SAT;
			end
		end
	end

	logic signed [31:0] ca_s8, cb_s8, cc_s8, cx_s8, cy_s8;
	litpi_pkg::status_t st_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ca_s8 <= ca_w;
			cb_s8 <= cb_w;
			cc_s8 <= cc_w;
			cx_s8 <= cx_w;
			cy_s8 <= cy_w;
			st_s8 <= st_w;
		end
	end

	assign res_valid = v_s8;
	assign coef_a    = ca_s8;
	assign coef_b    = cb_s8;
	assign coef_c    = cc_s8;
	assign cross_x   = cx_s8;
	assign cross_y   = cy_s8;
	assign status    = st_s8;

`ifndef SYNTHESIS
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !req_stall)
		else $error("request stalled with an empty output register");

	a_par_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == litpi_pkg::ST_PARALLEL |->
			coef_a == 32'sd0 && coef_b == 32'sd0 && coef_c == 32'sd0 &&
			cross_x == 32'sd0 && cross_y == 32'sd0)
		else $error("parallel result carries nonzero values");

	a_coef_a: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> coef_a == 32'sd0 || coef_a == ONE)
		else $error("coef_a is neither zero nor one");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == litpi_pkg::ST_SAT |->
			coef_b == litpi_pkg::Q_MAX || coef_b == litpi_pkg::Q_MIN ||
			coef_c == litpi_pkg::Q_MAX || coef_c == litpi_pkg::Q_MIN ||
			cross_x == litpi_pkg::Q_MAX || cross_x == litpi_pkg::Q_MIN ||
			cross_y == litpi_pkg::Q_MAX || cross_y == litpi_pkg::Q_MIN)
		else $error("saturation status without a saturated output");
`endif

endmodule

@@ tb/line_through_points_and_intersect_unit_test.sv @@
// Testbench for line_through_points_and_intersect_unit: make-line and intersect
// requests checked against a wide-integer predictor. Depends on litpi_pkg and the RTL.
`timescale 1ns / 1ps
module line_through_points_and_intersect_unit_test;

	localparam int FRAC     = 16;
	localparam int EPS      = 6;
	localparam int LATENCY  = 74;
	localparam int N_RANDOM = 1630;

	// wide signed type: every product and shifted dividend stays exact
	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic               op;
		logic signed [31:0] ax, az, bx, bz;
		logic signed [31:0] a1, b1, c1, a2, b2, c2;
	} line_req_t;

	typedef struct {
		logic signed [31:0] ca, cb, cc, x, y;
		litpi_pkg::status_t st;
	} line_res_t;

	logic clk, arst_n;
	logic req_valid, req_stall, operation;
	logic signed [31:0] point_a_x, point_a_z, point_b_x, point_b_z;
	logic signed [31:0] first_a, first_b, first_c, second_a, second_b, second_c;
	logic res_valid, res_stall;
	logic signed [31:0] coef_a, coef_b, coef_c, cross_x, cross_y;
	logic [1:0] status;

	line_through_points_and_intersect_unit dut (.*);

	line_req_t pending_reqs[$];   // requests not yet offered
	line_res_t expected_res[$];   // predictions for accepted requests
	int n_errors, n_checked, n_make, n_cross, n_par, n_sat;
	int n_sent, n_accepted;
	logic req_took;     // request accepted at the last rising edge
	logic want_drain;   // sender pause until every result is back
	int burst_left, gap_left;
	int stall_mode, mode_left, hold_left;
	logic hold_done;

	// clock: 20 ns period
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ---------------------------------------------------------------- predictor
	// floor(|n| * 2^f / |d|) capped at 2^40, sign applied after (toward zero)
	function automatic wide_t quot_trunc(input wide_t n, input int f, input wide_t d);
		wide_t mn, md, q;
		mn = (n < 0) ? -n : n;
		md = (d < 0) ? -d : d;
		q = (mn <<< f) / md;
		if (q > (wide_t'(1) <<< 40))
			q = wide_t'(1) <<< 40;
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic wide_t clamp32(input wide_t v, inout logic ovf);
		if (v > wide_t'(litpi_pkg::Q_MAX)) begin
			ovf = 1'b1;
			return wide_t'(litpi_pkg::Q_MAX);
		end
		if (v < wide_t'(litpi_pkg::Q_MIN)) begin
			ovf = 1'b1;
			return wide_t'(litpi_pkg::Q_MIN);
		end
		return v;
	endfunction

	function automatic line_res_t solve_line(input line_req_t r);
		line_res_t res;
		wide_t one, ca, cb, cc, x, y, dx;
		wide_t ax, az, bx, bz, a1, b1, c1, a2, b2, c2;
		logic ovf;
		one = wide_t'(1) <<< FRAC;
		ca = 0; cb = 0; cc = 0; x = 0; y = 0;
		ovf = 1'b0;
		res.st = litpi_pkg::ST_OK;
		ax = r.ax; az = r.az; bx = r.bx; bz = r.bz;
		a1 = r.a1; b1 = r.b1; c1 = r.c1; a2 = r.a2; b2 = r.b2; c2 = r.c2;
		if (r.op == litpi_pkg::OP_MAKE) begin
			dx = bx - ax;
			if (dx >= -EPS && dx <= EPS) begin
				// near-vertical: x = const
				ca = 0;
				cb = one;
			end else begin
				ca = one;
				cb = clamp32(quot_trunc(-(bz - az), FRAC, dx), ovf);
			end
			// saturated slope feeds c as is
			cc = ((ca != 0) ? -bz : wide_t'(0)) - (cb * bx) / one;
			cc = clamp32(cc, ovf);
		end else if (a1 * b2 == a2 * b1) begin
			res.st = litpi_pkg::ST_PARALLEL;
		end else if (a1 == 0) begin
			x = clamp32(quot_trunc(-c1, FRAC, b1), ovf);
			y = clamp32(quot_trunc(-(b2 * x + c2 * one), 0, a2), ovf);
		end else if (a2 == 0) begin
			x = clamp32(quot_trunc(-c2, FRAC, b2), ovf);
			y = clamp32(quot_trunc(-(b1 * x + c1 * one), 0, a1), ovf);
		end else begin
			x = clamp32(quot_trunc(a1 * c2 - a2 * c1, FRAC, a2 * b1 - a1 * b2), ovf);
			y = clamp32(quot_trunc(-(b1 * x + c1 * one), 0, a1), ovf);
		end
		if (res.st == litpi_pkg::ST_OK && ovf)
			res.st = litpi_pkg::ST_SAT;
		res.ca = ca[31:0]; res.cb = cb[31:0]; res.cc = cc[31:0];
		res.x = x[31:0]; res.y = y[31:0];
		return res;
	endfunction

	// ---------------------------------------------------------------- stimulus
	function automatic logic signed [31:0] pick_val();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			3: return ($signed($urandom_range(0, 16)) - 8) <<< FRAC;
			4: case ($urandom_range(0, 4))
				0: return litpi_pkg::Q_MIN;
				1: return litpi_pkg::Q_MAX;
				2: return 0;
				3: return 1;
				default: return -1;
			endcase
			default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
		endcase
	endfunction

	function automatic line_req_t rand_req();
		line_req_t r;
		int k;
		r.op = 1'($urandom_range(0, 1));
		r.ax = pick_val(); r.az = pick_val(); r.bx = pick_val(); r.bz = pick_val();
		r.a1 = pick_val(); r.b1 = pick_val(); r.c1 = pick_val();
		r.a2 = pick_val(); r.b2 = pick_val(); r.c2 = pick_val();
		if (r.op == litpi_pkg::OP_MAKE) begin
			// a third of the points land around the vertical threshold
			if ($urandom_range(0, 2) == 0)
				r.bx = r.ax + $signed($urandom_range(0, 16)) - 8;
		end else begin
			k = $signed($urandom_range(0, 6)) - 3;
			case ($urandom_range(0, 9))
				0, 1: begin   // parallel: second line scaled from the first
					r.a2 = r.a1 * k;
					r.b2 = r.b1 * k;
				end
				2, 3: r.a1 = 0;
				4, 5: r.a2 = 0;
				6: begin      // degenerate first line: a1 and b1 zero
					r.a1 = 0; r.b1 = 0;
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	function automatic line_req_t mk_make(input logic signed [31:0] ax, az, bx, bz);
		line_req_t r;
		r = rand_req();
		r.op = litpi_pkg::OP_MAKE;
		r.ax = ax; r.az = az; r.bx = bx; r.bz = bz;
		return r;
	endfunction

	function automatic line_req_t mk_cross(input logic signed [31:0] a1, b1, c1, a2, b2, c2);
		line_req_t r;
		r = rand_req();
		r.op = litpi_pkg::OP_CROSS;
		r.a1 = a1; r.b1 = b1; r.c1 = c1; r.a2 = a2; r.b2 = b2; r.c2 = c2;
		return r;
	endfunction

	initial begin
		localparam logic signed [31:0] ONE = 32'sh0001_0000;
		// make-line: vertical at and just past the threshold, both signs, then a plain slope
		pending_reqs.push_back(mk_make(0, 0, EPS, ONE));
		pending_reqs.push_back(mk_make(0, 0, -EPS, ONE));
		pending_reqs.push_back(mk_make(0, 0, EPS + 1, ONE));
		pending_reqs.push_back(mk_make(0, 0, -EPS - 1, -ONE));
		pending_reqs.push_back(mk_make(0, 0, 2 * ONE, 3 * ONE));
		// steep slope saturates and then drives c; then extreme and vertical points
		pending_reqs.push_back(mk_make(0, litpi_pkg::Q_MIN, 7, litpi_pkg::Q_MAX));
		pending_reqs.push_back(mk_make(litpi_pkg::Q_MIN, litpi_pkg::Q_MIN,
			litpi_pkg::Q_MAX, litpi_pkg::Q_MAX));
		pending_reqs.push_back(mk_make(litpi_pkg::Q_MAX, litpi_pkg::Q_MAX,
			litpi_pkg::Q_MIN, litpi_pkg::Q_MIN));
		pending_reqs.push_back(mk_make(litpi_pkg::Q_MAX, 0, litpi_pkg::Q_MAX,
			litpi_pkg::Q_MIN));
		pending_reqs.push_back(mk_make(-1, -1, -1, -1));
		// intersect: general, first vertical, second vertical
		pending_reqs.push_back(mk_cross(ONE, -ONE, 0, ONE, ONE, -2 * ONE));
		pending_reqs.push_back(mk_cross(0, ONE, -3 * ONE, ONE, 2 * ONE, ONE));
		pending_reqs.push_back(mk_cross(ONE, ONE, ONE, 0, ONE, -5 * ONE));
		// parallel, all-zero and degenerate lines
		pending_reqs.push_back(mk_cross(ONE, 2 * ONE, 0, 2 * ONE, 4 * ONE, ONE));
		pending_reqs.push_back(mk_cross(0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk_cross(0, 0, ONE, ONE, ONE, ONE));
		// extremes, where x may saturate and y follows from the clamped x
		pending_reqs.push_back(mk_cross(0, 1, litpi_pkg::Q_MAX, ONE, litpi_pkg::Q_MAX,
			litpi_pkg::Q_MIN));
		pending_reqs.push_back(mk_cross(litpi_pkg::Q_MIN, litpi_pkg::Q_MAX,
			litpi_pkg::Q_MIN, litpi_pkg::Q_MAX, litpi_pkg::Q_MIN, litpi_pkg::Q_MAX));
		pending_reqs.push_back(mk_cross(litpi_pkg::Q_MIN, litpi_pkg::Q_MIN,
			litpi_pkg::Q_MIN, 1, -1, litpi_pkg::Q_MAX));
		pending_reqs.push_back(mk_cross(1, litpi_pkg::Q_MIN, litpi_pkg::Q_MAX, -1,
			litpi_pkg::Q_MIN, litpi_pkg::Q_MIN));
		repeat (N_RANDOM)
			pending_reqs.push_back(rand_req());
	end

	// ---------------------------------------------------------------- reset
	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0; res_stall = 1'b0; operation = 1'b0;
		point_a_x = 0; point_a_z = 0; point_b_x = 0; point_b_z = 0;
		first_a = 0; first_b = 0; first_c = 0;
		second_a = 0; second_b = 0; second_c = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ---------------------------------------------------------------- driver
	// Bursts of random length, random gaps; one pause until the pipe drains.
	always @(negedge clk) begin
		line_req_t r;
		logic next_valid;
		if (arst_n) begin
			next_valid = req_valid;
			if (!req_valid || req_took) begin
				next_valid = 1'b0;
				if (n_sent == 900 && !want_drain && expected_res.size() != 0)
					want_drain <= 1'b1;
				if (want_drain || (n_sent == 900 && expected_res.size() != 0)) begin
					if (expected_res.size() == 0 && want_drain) begin
						want_drain <= 1'b0;
						n_sent <= n_sent + 1;   // step past the pause point
					end
				end else if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (pending_reqs.size() != 0) begin
					r = pending_reqs.pop_front();
					operation <= r.op;
					point_a_x <= r.ax; point_a_z <= r.az;
					point_b_x <= r.bx; point_b_z <= r.bz;
					first_a <= r.a1; first_b <= r.b1; first_c <= r.c1;
					second_a <= r.a2; second_b <= r.b2; second_c <= r.c2;
					next_valid = 1'b1;
					if (n_sent != 900)
						n_sent <= n_sent + 1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
			req_valid <= next_valid;
		end
	end

	initial begin
		want_drain = 1'b0;
		n_sent = 0;
		burst_left = 0;
		gap_left = 0;
	end

	// accepted request: predict and queue its result
	always @(posedge clk) begin
		line_req_t r;
		req_took <= req_valid && !req_stall;
		if (arst_n && req_valid && !req_stall) begin
			r.op = operation;
			r.ax = point_a_x; r.az = point_a_z; r.bx = point_b_x; r.bz = point_b_z;
			r.a1 = first_a; r.b1 = first_b; r.c1 = first_c;
			r.a2 = second_a; r.b2 = second_b; r.c2 = second_c;
			expected_res.push_back(solve_line(r));
			n_accepted <= n_accepted + 1;
			if (r.op == litpi_pkg::OP_MAKE)
				n_make <= n_make + 1;
			else
				n_cross <= n_cross + 1;
		end
	end

	// ---------------------------------------------------------------- receiver
	// Stall pattern changes mode every so often; one long hold-off fills the pipe.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && n_accepted >= 300) begin
				hold_done <= 1'b1;
				hold_left <= 3 * LATENCY;
				res_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode <= $urandom_range(0, 3);
					mode_left <= $urandom_range(20, 300);
				end else begin
					mode_left <= mode_left - 1;
				end
				case (stall_mode)
					0: res_stall <= 1'b0;
					1: res_stall <= ($urandom_range(0, 3) == 0);
					2: res_stall <= ($urandom_range(0, 9) < 7);
					default: res_stall <= ~res_stall;
				endcase
			end
		end
	end

	initial begin
		hold_done = 1'b0;
		hold_left = 0;
		stall_mode = 0;
		mode_left = 0;
		n_accepted = 0;
		n_errors = 0; n_checked = 0;
		n_make = 0; n_cross = 0; n_par = 0; n_sat = 0;
	end

	// ---------------------------------------------------------------- monitor
	task automatic report_mismatch(input string what, input logic [31:0] got, want);
		$display("mismatch %0s result %0d: got %h want %h", what, n_checked, got, want);
		n_errors++;
	endtask

	always @(posedge clk) begin
		line_res_t e;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_res.size() == 0) begin
				report_mismatch("unexpected", 32'(status), 32'd0);
			end else begin
				e = expected_res.pop_front();
				if (coef_a !== e.ca)  report_mismatch("coef_a", coef_a, e.ca);
				if (coef_b !== e.cb)  report_mismatch("coef_b", coef_b, e.cb);
				if (coef_c !== e.cc)  report_mismatch("coef_c", coef_c, e.cc);
				if (cross_x !== e.x)  report_mismatch("cross_x", cross_x, e.x);
				if (cross_y !== e.y)  report_mismatch("cross_y", cross_y, e.y);
				if (status !== e.st)  report_mismatch("status", status, e.st);
				if (e.st == litpi_pkg::ST_PARALLEL) n_par++;
				if (e.st == litpi_pkg::ST_SAT)      n_sat++;
				n_checked++;
			end
		end
	end

	// ---------------------------------------------------------------- end of run
	initial begin
		wait (arst_n);
		while (pending_reqs.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_res.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (expected_res.size() != 0) begin
			$display("%0d results never arrived", expected_res.size());
			n_errors++;
		end
		$display("checked %0d results: %0d make-line, %0d intersect", n_checked, n_make, n_cross);
		$display("parallel or degenerate %0d, saturated %0d, mismatches %0d",
			n_par, n_sat, n_errors);
		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#4ms;
		$display("timeout");
		$display("status: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/litpi_pkg.sv
rtl/core/litpi_div.sv
rtl/core/litpi_front.sv
rtl/core/litpi_mid.sv
rtl/core/line_through_points_and_intersect_unit.sv
tb/line_through_points_and_intersect_unit_test.sv
